[src/wfae_pkg.sv]
// ----------------------------------------------------------------------------
// WLAN frame airtime estimator package
// Shared types, constants and lookup tables for the airtime estimator.
// ----------------------------------------------------------------------------
package wfae_pkg;

    localparam int NUM_W     = 21;
    localparam int DEN_W     = 14;
    localparam int DUR_W     = 21;
    localparam int EXTRA_W   = 15;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [7:0] TYPE_MASK  = 8'hFC;
    localparam logic [7:0] FT_CTS     = 8'hC4;
    localparam logic [7:0] FT_ACK     = 8'hD4;
    localparam logic [7:0] FT_BEACON  = 8'h80;
    localparam logic [7:0] FT_QOSDATA = 8'h88;
    localparam logic [3:0] DATA_MASK  = 4'hC;
    localparam logic [3:0] DATA_TYPE  = 4'h8;

    localparam logic [1:0] MODE_B = 2'd0;
    localparam logic [1:0] MODE_A = 2'd1;

    localparam logic [4:0] OFDM_SIFS = 5'd16;
    localparam logic [4:0] CCK_SIFS  = 5'd10;
    localparam logic [4:0] SLOT_SHORT = 5'd9;
    localparam logic [4:0] SLOT_LONG  = 5'd20;

    localparam logic [7:0] PRE_SHORT = 8'd96;
    localparam logic [7:0] PRE_LONG  = 8'd192;
    localparam logic [4:0] OFDM_PRE  = 5'd20;
    localparam logic [7:0] OFDM_EXTRA_BITS_X10 = 8'd220;

    localparam logic [3:0] DEF_CWMIN = 4'd4;
    localparam logic [3:0] DEF_CWMAX = 4'd10;

    localparam logic [1:0] UP_TO_AC [8] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3};
    localparam logic [2:0] AC_AIFS  [4] = '{3'd3, 3'd7, 3'd2, 3'd2};
    localparam logic [3:0] AC_CWMIN [4] = '{4'd4, 4'd4, 4'd3, 4'd2};
    localparam logic [3:0] AC_CWMAX [4] = '{4'd10, 4'd10, 4'd4, 4'd3};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_step;
    } t_status;

endpackage

[src/wfae_ctrl.sv]
// ----------------------------------------------------------------------------
// Airtime estimator controller
// Sequences load, division steps and result hand-off, and owns the handshakes.
// ----------------------------------------------------------------------------
module wfae_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  wfae_pkg::t_status i_status,
    output wfae_pkg::t_cmd    o_cmd
);

    wfae_pkg::t_state r_state, n_state;
    logic             r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfae_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_valid = r_valid && i_stall;
        case (r_state)
            wfae_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = wfae_pkg::ST_DIV;
                end
            end
            wfae_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = wfae_pkg::ST_FIN;
                end
            end
            wfae_pkg::ST_FIN: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = wfae_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wfae_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != wfae_pkg::ST_IDLE);
    assign o_valid = r_valid;

endmodule

[src/wfae_dp.sv]
// ----------------------------------------------------------------------------
// Airtime estimator datapath
// Operand setup, restoring divider, interframe and backoff term, result sum.
// ----------------------------------------------------------------------------
module wfae_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wfae_pkg::t_cmd              i_cmd,
    output wfae_pkg::t_status           o_status,
    input  logic [1:0]                  i_phy_mode,
    input  logic [13:0]                 i_frame_length,
    input  logic [11:0]                 i_rate_100kbps,
    input  logic                        i_short_preamble,
    input  logic                        i_short_slot,
    input  logic [7:0]                  i_frame_type,
    input  logic [2:0]                  i_user_priority,
    input  logic [3:0]                  i_retries,
    output logic [wfae_pkg::DUR_W-1:0]  o_duration_us
);

    function automatic logic [13:0] backoff(input logic [3:0] cwmin, input logic [3:0] cwmax,
                                            input logic [3:0] retries, input logic [4:0] slot);
        logic [4:0]  e;
        logic [9:0]  win;
        logic [14:0] prod;
        e = {1'b0, cwmin} + {1'b0, retries};
        if (e > {1'b0, cwmax}) begin
            e = {1'b0, cwmax};
        end
        win  = 10'((11'd1 << e) - 11'd1);
        prod = {5'd0, win} * {10'd0, slot};
        return prod[14:1];
    endfunction

    logic                            r_prev_cts;
    logic [wfae_pkg::CNT_W-1:0]      r_cnt;
    logic [wfae_pkg::NUM_W-1:0]      r_q;
    logic [wfae_pkg::DEN_W-1:0]      r_rem;
    logic [wfae_pkg::DEN_W-1:0]      r_den;
    logic [wfae_pkg::EXTRA_W-1:0]    r_extra;
    logic                            r_ofdm;
    logic                            r_short_pre;
    logic [wfae_pkg::DUR_W-1:0]      r_dur;

    logic [11:0]                     rate;
    logic                            cck_rate, ofdm;
    logic [14:0]                     len_p4;
    logic [wfae_pkg::NUM_W-1:0]      num;
    logic [wfae_pkg::DEN_W-1:0]      den;
    logic [4:0]                      sifs, slot;
    logic [7:0]                      ft;
    logic [1:0]                      ac;
    logic [wfae_pkg::EXTRA_W-1:0]    extra;
    logic [wfae_pkg::DEN_W:0]        rem_sh, rem_sub;
    logic                            qbit;
    logic [21:0]                     q_c;
    logic [22:0]                     tx, dur;

    always_comb begin
        rate     = (i_rate_100kbps == 12'd0) ? 12'd1 : i_rate_100kbps;
        cck_rate = (rate == 12'd10) || (rate == 12'd20) || (rate == 12'd55) || (rate == 12'd110);
        ofdm     = (i_phy_mode == wfae_pkg::MODE_A) || (i_phy_mode[1] && !cck_rate);
        len_p4   = {1'b0, i_frame_length} + 15'd4;
        num      = ({6'd0, len_p4} << 6) + ({6'd0, len_p4} << 4)
                 + (ofdm ? {13'd0, wfae_pkg::OFDM_EXTRA_BITS_X10} : '0);
        den      = ofdm ? {rate, 2'b00} : {2'b00, rate};
        sifs     = ofdm ? wfae_pkg::OFDM_SIFS : wfae_pkg::CCK_SIFS;
        slot     = (ofdm || i_short_slot) ? wfae_pkg::SLOT_SHORT : wfae_pkg::SLOT_LONG;
        ft       = i_frame_type & wfae_pkg::TYPE_MASK;
        ac       = wfae_pkg::UP_TO_AC[i_user_priority];
        if (ft == wfae_pkg::FT_CTS || ft == wfae_pkg::FT_ACK) begin
            extra = {10'd0, sifs};
        end else if (ft == wfae_pkg::FT_BEACON) begin
            extra = {10'd0, sifs} + {9'd0, slot, 1'b0} + {11'd0, slot[4:1]};
        end else if ((i_frame_type[3:0] & wfae_pkg::DATA_MASK) == wfae_pkg::DATA_TYPE
                     && r_prev_cts) begin
            extra = {10'd0, sifs};
        end else if (ft == wfae_pkg::FT_QOSDATA) begin
            extra = {10'd0, sifs}
                  + {7'd0, 8'({5'd0, wfae_pkg::AC_AIFS[ac]} * {3'd0, slot})}
                  + {1'b0, backoff(wfae_pkg::AC_CWMIN[ac], wfae_pkg::AC_CWMAX[ac],
                                   i_retries, slot)};
        end else begin
            extra = {10'd0, sifs} + {9'd0, slot, 1'b0}
                  + {1'b0, backoff(wfae_pkg::DEF_CWMIN, wfae_pkg::DEF_CWMAX, i_retries, slot)};
        end
    end

    always_comb begin
        rem_sh  = {r_rem, r_q[wfae_pkg::NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        qbit    = (rem_sh >= {1'b0, r_den});
        q_c     = {1'b0, r_q} + {21'd0, (r_rem != '0)};
        tx      = r_ofdm ? ({18'd0, wfae_pkg::OFDM_PRE} + {q_c[20:0], 2'b00})
                         : ({15'd0, (r_short_pre ? wfae_pkg::PRE_SHORT : wfae_pkg::PRE_LONG)}
                            + {1'b0, q_c});
        dur     = tx + {8'd0, r_extra};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cts <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cmd.load) begin
            r_prev_cts <= (ft == wfae_pkg::FT_CTS);
            r_cnt      <= '0;
        end else if (i_cmd.step) begin
            r_cnt      <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q         <= num;
            r_rem       <= '0;
            r_den       <= den;
            r_extra     <= extra;
            r_ofdm      <= ofdm;
            r_short_pre <= i_short_preamble;
        end else if (i_cmd.step) begin
            r_q   <= {r_q[wfae_pkg::NUM_W-2:0], qbit};
            r_rem <= qbit ? rem_sub[wfae_pkg::DEN_W-1:0] : rem_sh[wfae_pkg::DEN_W-1:0];
        end
        if (i_cmd.finish) begin
            r_dur <= dur[wfae_pkg::DUR_W-1:0];
        end
    end

    assign o_status.last_step = (r_cnt == wfae_pkg::CNT_W'(wfae_pkg::DIV_STEPS - 1));
    assign o_duration_us      = r_dur;

endmodule

[src/wlan_frame_airtime_estimator.sv]
// ----------------------------------------------------------------------------
// WLAN frame airtime estimator
// Estimates the medium time of one 802.11 frame in microseconds.
// ----------------------------------------------------------------------------
// An accepted word is loaded and run through the one-bit-per-cycle divider,
// which takes 21 steps; the result is then written unless a held result is
// stalled. A new word is accepted only after its result has been written.
// The result register lets the next word be accepted while a result waits.
// Reset is synchronous and active low; it clears the controller, the divider
// step counter and the previous-CTS flag.
module wlan_frame_airtime_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_phy_mode,
    input  logic [13:0] i_frame_length,
    input  logic [11:0] i_rate_100kbps,
    input  logic        i_short_preamble,
    input  logic        i_short_slot,
    input  logic [7:0]  i_frame_type,
    input  logic [2:0]  i_user_priority,
    input  logic [3:0]  i_retries,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_duration_us
);

    wfae_pkg::t_cmd    cmd;
    wfae_pkg::t_status status;

    wfae_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    wfae_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_phy_mode       (i_phy_mode),
        .i_frame_length   (i_frame_length),
        .i_rate_100kbps   (i_rate_100kbps),
        .i_short_preamble (i_short_preamble),
        .i_short_slot     (i_short_slot),
        .i_frame_type     (i_frame_type),
        .i_user_priority  (i_user_priority),
        .i_retries        (i_retries),
        .o_duration_us    (o_duration_us)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("controller issued more than one command");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a word was accepted");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !(o_valid && i_stall))
        else $error("result overwritten while still held");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_valid)
        else $error("result word not presented after finish");

endmodule
